// ----- src/dst_pkg.sv -----
// Shared types and constants for the duration statistics table.
package dst_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned NumSlots = 16;

  typedef enum logic [2:0] {
    ReqStart    = 3'd0,
    ReqEnd      = 3'd1,
    ReqRecord   = 3'd2,
    ReqResetOne = 3'd3,
    ReqResetAll = 3'd4,
    ReqQuery    = 3'd5,
    ReqRsvd6    = 3'd6,
    ReqRsvd7    = 3'd7
  } req_e;

  // Classified item passed from the front to the back.
  typedef struct packed {
    req_e             req;
    logic             ok;
    logic [CfgW-1:0]  lim;
    logic [SlotW-1:0] slot;
    logic [DataW-1:0] dur;
    logic [DataW-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic             slot_valid;
    logic [DataW-1:0] duration_out;
    logic [DataW-1:0] hit_count;
    logic [DataW-1:0] average;
    logic [DataW-1:0] min_duration;
    logic [DataW-1:0] max_duration;
    logic [DataW-1:0] total_duration;
  } res_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StClear,
    StDiv,
    StOut
  } st_e;

endpackage

// ----- src/dst_front.sv -----
// Front end: accepts requests, checks the slot and queues classified commands.
module dst_front import dst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [2:0]       req_type_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [DataW-1:0] duration_in_i,
  input  logic [DataW-1:0] now_ms_i,
  input  logic [CfgW-1:0]  slots_in_use_i,
  output logic             cmd_valid_o,
  input  logic             cmd_take_i,
  output cmd_t             cmd_o
);

  localparam logic [8:0] NumSlotsW = 9'(NumSlots);

  cmd_t       buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic [8:0] lim9;
  logic [CfgW-1:0] lim;
  cmd_t       cmd_in;
  logic       do_push, do_pop;

  assign lim9 = (9'(slots_in_use_i) < NumSlotsW) ? 9'(slots_in_use_i) : NumSlotsW;
  assign lim  = (lim9 > 9'(16)) ? CfgW'(16) : lim9[CfgW-1:0];

  always_comb begin
    cmd_in      = '0;
    cmd_in.req  = req_e'(req_type_i);
    cmd_in.slot = slot_i;
    cmd_in.lim  = lim;
    cmd_in.ok   = {1'b0, slot_i} < lim;
    cmd_in.dur  = duration_in_i;
    cmd_in.now  = now_ms_i;
  end

  assign full_o      = cnt_q == 2'd2;
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign do_pop      = cmd_valid_o && cmd_take_i;
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= cmd_in;
  end

endmodule

// ----- src/dst_div.sv -----
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
module dst_div import dst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             busy_o,
  output logic [DataW-1:0] quo_o
);

  logic [DataW-1:0] quo_q, den_q;
  logic [DataW:0]   rem_q, trial;
  logic [5:0]       cnt_q;

  assign trial  = {rem_q[DataW-1:0], quo_q[DataW-1]} - {1'b0, den_q};
  assign busy_o = cnt_q != 6'd0;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 6'(DataW);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_o) begin
      if (!trial[DataW]) begin
        rem_q <= trial;
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DataW-1:0], quo_q[DataW-1]};
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/dst_back.sv -----
// Back end: slot store update, average division and result register.
module dst_back import dst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  output logic  cmd_take_o,
  input  cmd_t  cmd_i,
  output logic  empty_o,
  input  logic  pop_i,
  output res_t  res_o
);

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam logic [DataW-1:0] AllOnes = '1;

  logic [DataW-1:0] start_q [NumSlots];
  logic [DataW-1:0] last_q  [NumSlots];
  logic [DataW-1:0] cnt_q   [NumSlots];
  logic [DataW-1:0] tot_q   [NumSlots];
  logic [DataW-1:0] min_q   [NumSlots];
  logic [DataW-1:0] max_q   [NumSlots];

  st_e  st_q, st_d;
  cmd_t cmd_q;
  res_t res_q, res_d;
  logic full_q;
  logic [IdxW-1:0] idx, clr_q;
  logic [DataW-1:0] d_val;
  logic div_start, div_busy;
  logic [DataW-1:0] div_quo;
  logic [CfgW-1:0]  clr_next;

  assign idx      = cmd_q.slot[IdxW-1:0];
  assign d_val    = (cmd_q.req == ReqEnd) ? cmd_q.now - start_q[idx] : cmd_q.dur;
  assign clr_next = CfgW'(clr_q) + CfgW'(1);

  dst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (res_d.total_duration),
    .den_i  (res_d.hit_count),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (cmd_valid_i && !full_q) st_d = StRead;
      StRead:  st_d = (cmd_q.req == ReqResetAll && cmd_q.lim != '0) ? StClear : StDiv;
      StClear: if (clr_next >= cmd_q.lim) st_d = StOut;
      StDiv:   if (!div_busy && !full_q && !div_start) st_d = StIdle;
      StOut:   st_d = StDiv;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_take_o = st_q == StIdle && !full_q;
    div_start  = (st_q == StRead && st_d == StDiv) || st_q == StOut;
  end

  // Result once the store has settled for this command.
  always_comb begin
    res_d = '0;
    if (cmd_q.ok) begin
      res_d.slot_valid     = 1'b1;
      res_d.duration_out   = last_q[idx];
      res_d.hit_count      = cnt_q[idx];
      res_d.min_duration   = min_q[idx];
      res_d.max_duration   = max_q[idx];
      res_d.total_duration = tot_q[idx];
      unique case (cmd_q.req)
        ReqEnd, ReqRecord: begin
          res_d.duration_out   = d_val;
          res_d.hit_count      = cnt_q[idx] + 32'd1;
          res_d.total_duration = tot_q[idx] + d_val;
          if (d_val < min_q[idx]) res_d.min_duration = d_val;
          if (d_val > max_q[idx]) res_d.max_duration = d_val;
        end
        ReqResetOne: begin
          res_d.duration_out   = '0;
          res_d.hit_count      = '0;
          res_d.total_duration = '0;
          res_d.min_duration   = AllOnes;
          res_d.max_duration   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      full_q <= 1'b0;
      clr_q  <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        start_q[i] <= '0;
        last_q[i]  <= '0;
        cnt_q[i]   <= '0;
        tot_q[i]   <= '0;
        min_q[i]   <= AllOnes;
        max_q[i]   <= '0;
      end
    end else begin
      st_q <= st_d;
      if (pop_i && full_q) full_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          clr_q <= '0;
        end
        StRead: begin
          if (cmd_q.req != ReqResetAll && cmd_q.ok) begin
            unique case (cmd_q.req)
              ReqStart: start_q[idx] <= cmd_q.now;
              ReqEnd, ReqRecord, ReqResetOne: begin
                last_q[idx] <= res_d.duration_out;
                cnt_q[idx]  <= res_d.hit_count;
                tot_q[idx]  <= res_d.total_duration;
                min_q[idx]  <= res_d.min_duration;
                max_q[idx]  <= res_d.max_duration;
              end
              default: ;
            endcase
          end
        end
        StClear: begin
          last_q[clr_q] <= '0;
          cnt_q[clr_q]  <= '0;
          tot_q[clr_q]  <= '0;
          min_q[clr_q]  <= AllOnes;
          max_q[clr_q]  <= '0;
          clr_q         <= clr_q + IdxW'(1);
        end
        StDiv: begin
          if (st_d == StIdle) full_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_valid_i) cmd_q <= cmd_i;
    if (st_q == StRead || st_q == StOut) res_q <= res_d;
    if (st_q == StDiv && st_d == StIdle) begin
      res_q.average <= (res_q.hit_count != '0) ? div_quo : '0;
    end
  end

  assign empty_o = !full_q;
  assign res_o   = res_q;

endmodule

// ----- src/duration_statistics_table.sv -----
// Top level of the duration statistics table.
// An accepted request passes through read, the average division and the result register;
// reset all first clears each slot in use in turn. The back end takes a new request
// only once the single result register has been popped; the front end queues up to two.
// Reset: asynchronous, active low; all slots cleared, minimum to all ones, queues empty.
module duration_statistics_table import dst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       req_type_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [DataW-1:0] duration_in_i,
  input  logic [DataW-1:0] now_ms_i,
  output logic             empty,
  input  logic             pop,
  output logic             slot_valid_o,
  output logic [DataW-1:0] duration_out_o,
  output logic [DataW-1:0] hit_count_o,
  output logic [DataW-1:0] average_o,
  output logic [DataW-1:0] min_duration_o,
  output logic [DataW-1:0] max_duration_o,
  output logic [DataW-1:0] total_duration_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CfgW-1:0]  cfg_data_i
);

  logic [CfgW-1:0] slots_q;
  logic cmd_valid, cmd_take;
  cmd_t cmd;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
    end else if (cfg_valid_i) begin
      slots_q <= cfg_data_i;
    end
  end

  dst_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .req_type_i, .slot_i, .duration_in_i, .now_ms_i,
    .slots_in_use_i(slots_q),
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  dst_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign slot_valid_o     = res.slot_valid;
  assign duration_out_o   = res.duration_out;
  assign hit_count_o      = res.hit_count;
  assign average_o        = res.average;
  assign min_duration_o   = res.min_duration;
  assign max_duration_o   = res.max_duration;
  assign total_duration_o = res.total_duration;

endmodule
